@@ rtl/tot_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tot_pkg
// shared constants and helpers of the two-triangle overlap test
// ----------------------------------------------------------------------------
package tot_pkg;

    // edges of one triangle, edge k runs from vertex k to vertex (k+1) mod NUM_EDGES
    localparam int NUM_EDGES = 3;

    function automatic int next_vtx(input int idx);
        next_vtx = (idx + 1) % NUM_EDGES;
    endfunction

    // n / d within [0, 1] without dividing, for either sign of d
    function automatic logic span_ok(
        input logic n_ge_zero,
        input logic n_le_zero,
        input logic n_le_d,
        input logic n_ge_d,
        input logic d_neg
    );
        span_ok = d_neg ? (n_le_zero && n_ge_d) : (n_ge_zero && n_le_d);
    endfunction

endpackage

@@ rtl/tot_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tot_pair_if / tot_res_if
// valid/ready channels for triangle pairs and overlap results
// ----------------------------------------------------------------------------
interface tot_pair_if #(
    parameter int COORD_WIDTH = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] a_x;
    logic signed [COORD_WIDTH-1:0] a_y;
    logic signed [COORD_WIDTH-1:0] b_x;
    logic signed [COORD_WIDTH-1:0] b_y;
    logic signed [COORD_WIDTH-1:0] c_x;
    logic signed [COORD_WIDTH-1:0] c_y;
    logic signed [COORD_WIDTH-1:0] d_x;
    logic signed [COORD_WIDTH-1:0] d_y;
    logic signed [COORD_WIDTH-1:0] e_x;
    logic signed [COORD_WIDTH-1:0] e_y;
    logic signed [COORD_WIDTH-1:0] f_x;
    logic signed [COORD_WIDTH-1:0] f_y;

    modport source (
        output valid, a_x, a_y, b_x, b_y, c_x, c_y, d_x, d_y, e_x, e_y, f_x, f_y,
        input  ready
    );
    modport sink (
        input  valid, a_x, a_y, b_x, b_y, c_x, c_y, d_x, d_y, e_x, e_y, f_x, f_y,
        output ready
    );
endinterface

interface tot_res_if;
    logic valid;
    logic ready;
    logic overlap;

    modport source (output valid, overlap, input ready);
    modport sink   (input valid, overlap, output ready);
endinterface

@@ rtl/tot_edge_pair.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tot_edge_pair
// segment p0-p1 against segment q0-q1: product stage, then decision logic
// ----------------------------------------------------------------------------
module tot_edge_pair #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic signed [COORD_WIDTH-1:0] i_p0_x,
    input  logic signed [COORD_WIDTH-1:0] i_p0_y,
    input  logic signed [COORD_WIDTH-1:0] i_p1_x,
    input  logic signed [COORD_WIDTH-1:0] i_p1_y,
    input  logic signed [COORD_WIDTH-1:0] i_q0_x,
    input  logic signed [COORD_WIDTH-1:0] i_q0_y,
    input  logic signed [COORD_WIDTH-1:0] i_q1_x,
    input  logic signed [COORD_WIDTH-1:0] i_q1_y,
    output logic                          o_meet
);

    localparam int DW = COORD_WIDTH + 1;
    localparam int PW = 2 * DW;
    localparam int SW = PW + 1;

    // signed zero so that every ordering compare stays signed
    localparam logic signed [SW-1:0] ZERO = '0;

    // edge vectors and offsets from p0
    logic signed [DW-1:0] rx, ry, sx, sy, wx, wy, vx, vy;

    assign rx = DW'(i_p1_x) - DW'(i_p0_x);
    assign ry = DW'(i_p1_y) - DW'(i_p0_y);
    assign sx = DW'(i_q1_x) - DW'(i_q0_x);
    assign sy = DW'(i_q1_y) - DW'(i_q0_y);
    assign wx = DW'(i_q0_x) - DW'(i_p0_x);
    assign wy = DW'(i_q0_y) - DW'(i_p0_y);
    assign vx = DW'(i_q1_x) - DW'(i_p0_x);
    assign vy = DW'(i_q1_y) - DW'(i_p0_y);

    logic signed [PW-1:0] r_den_a, r_den_b, r_tn_a, r_tn_b, r_un_a, r_un_b;
    logic signed [PW-1:0] r_rr_a, r_rr_b, r_n0_a, r_n0_b, r_n1_a, r_n1_b;
    logic signed [PW-1:0] r_ws_a, r_ws_b, r_ss_a, r_ss_b;
    logic                 r_wz;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_den_a <= PW'(rx) * PW'(sy);
            r_den_b <= PW'(ry) * PW'(sx);
            r_tn_a  <= PW'(wx) * PW'(sy);
            r_tn_b  <= PW'(wy) * PW'(sx);
            r_un_a  <= PW'(wx) * PW'(ry);
            r_un_b  <= PW'(wy) * PW'(rx);
            r_rr_a  <= PW'(rx) * PW'(rx);
            r_rr_b  <= PW'(ry) * PW'(ry);
            r_n0_a  <= PW'(wx) * PW'(rx);
            r_n0_b  <= PW'(wy) * PW'(ry);
            r_n1_a  <= PW'(vx) * PW'(rx);
            r_n1_b  <= PW'(vy) * PW'(ry);
            r_ws_a  <= PW'(wx) * PW'(sx);
            r_ws_b  <= PW'(wy) * PW'(sy);
            r_ss_a  <= PW'(sx) * PW'(sx);
            r_ss_b  <= PW'(sy) * PW'(sy);
            r_wz    <= (wx == '0) && (wy == '0);
        end
    end

    logic signed [SW-1:0] den, tn, un, rr, n0, n1, ws, ss;
    logic                 deg_hit, par_hit, gen_hit;

    always_comb begin
        den = SW'(r_den_a) - SW'(r_den_b);
        tn  = SW'(r_tn_a)  - SW'(r_tn_b);
        un  = SW'(r_un_a)  - SW'(r_un_b);
        rr  = SW'(r_rr_a)  + SW'(r_rr_b);
        n0  = SW'(r_n0_a)  + SW'(r_n0_b);
        n1  = SW'(r_n1_a)  + SW'(r_n1_b);
        ws  = SW'(r_ws_a)  + SW'(r_ws_b);
        ss  = SW'(r_ss_a)  + SW'(r_ss_b);

        // p0-p1 shrunk to a point: p0 on q0-q1
        deg_hit = (tn == '0) && (ws <= ZERO) && (ws >= -ss);
        // collinear: projected intervals overlap
        par_hit = (un == '0) && ((n0 >= ZERO) || (n1 >= ZERO))
               && ((n0 <= rr) || (n1 <= rr));
        // non-parallel: segments cross or touch, ends included
        gen_hit = tot_pkg::span_ok(tn >= ZERO, tn <= ZERO, tn <= den, tn >= den, den < ZERO)
               && tot_pkg::span_ok(un >= ZERO, un <= ZERO, un <= den, un >= den, den < ZERO);

        if (rr == '0) begin
            o_meet = (ss == '0) ? r_wz : deg_hit;
        end else if (den == '0) begin
            o_meet = par_hit;
        end else begin
            o_meet = gen_hit;
        end
    end

endmodule

@@ rtl/tot_inside.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tot_inside
// point in closed triangle, zero-area triangles answer no
// ----------------------------------------------------------------------------
module tot_inside #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic signed [COORD_WIDTH-1:0] i_pt_x,
    input  logic signed [COORD_WIDTH-1:0] i_pt_y,
    input  logic signed [COORD_WIDTH-1:0] i_t0_x,
    input  logic signed [COORD_WIDTH-1:0] i_t0_y,
    input  logic signed [COORD_WIDTH-1:0] i_t1_x,
    input  logic signed [COORD_WIDTH-1:0] i_t1_y,
    input  logic signed [COORD_WIDTH-1:0] i_t2_x,
    input  logic signed [COORD_WIDTH-1:0] i_t2_y,
    output logic                          o_inside
);

    localparam int DW = COORD_WIDTH + 1;
    localparam int PW = 2 * DW;
    localparam int SW = PW + 1;

    // signed zero so that the side tests stay signed
    localparam logic signed [SW-1:0] ZERO = '0;

    logic signed [DW-1:0] e01x, e01y, e12x, e12y, e20x, e20y, e02x, e02y;
    logic signed [DW-1:0] p0x, p0y, p1x, p1y, p2x, p2y;

    assign e01x = DW'(i_t1_x) - DW'(i_t0_x);
    assign e01y = DW'(i_t1_y) - DW'(i_t0_y);
    assign e12x = DW'(i_t2_x) - DW'(i_t1_x);
    assign e12y = DW'(i_t2_y) - DW'(i_t1_y);
    assign e20x = DW'(i_t0_x) - DW'(i_t2_x);
    assign e20y = DW'(i_t0_y) - DW'(i_t2_y);
    assign e02x = DW'(i_t2_x) - DW'(i_t0_x);
    assign e02y = DW'(i_t2_y) - DW'(i_t0_y);
    assign p0x  = DW'(i_pt_x) - DW'(i_t0_x);
    assign p0y  = DW'(i_pt_y) - DW'(i_t0_y);
    assign p1x  = DW'(i_pt_x) - DW'(i_t1_x);
    assign p1y  = DW'(i_pt_y) - DW'(i_t1_y);
    assign p2x  = DW'(i_pt_x) - DW'(i_t2_x);
    assign p2y  = DW'(i_pt_y) - DW'(i_t2_y);

    logic signed [PW-1:0] r_ar_a, r_ar_b, r_o1_a, r_o1_b, r_o2_a, r_o2_b, r_o3_a, r_o3_b;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ar_a <= PW'(e01x) * PW'(e02y);
            r_ar_b <= PW'(e01y) * PW'(e02x);
            r_o1_a <= PW'(e01x) * PW'(p0y);
            r_o1_b <= PW'(e01y) * PW'(p0x);
            r_o2_a <= PW'(e12x) * PW'(p1y);
            r_o2_b <= PW'(e12y) * PW'(p1x);
            r_o3_a <= PW'(e20x) * PW'(p2y);
            r_o3_b <= PW'(e20y) * PW'(p2x);
        end
    end

    logic signed [SW-1:0] area, o1, o2, o3;
    logic                 any_neg, any_pos;

    always_comb begin
        area    = SW'(r_ar_a) - SW'(r_ar_b);
        o1      = SW'(r_o1_a) - SW'(r_o1_b);
        o2      = SW'(r_o2_a) - SW'(r_o2_b);
        o3      = SW'(r_o3_a) - SW'(r_o3_b);
        any_neg = (o1 < ZERO) || (o2 < ZERO) || (o3 < ZERO);
        any_pos = (o1 > ZERO) || (o2 > ZERO) || (o3 > ZERO);
        o_inside = (area != '0) && !(any_neg && any_pos);
    end

endmodule

@@ rtl/triangle_overlap_test_2d.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_overlap_test_2d
// flags whether two triangles in the plane share at least one point
// ----------------------------------------------------------------------------
//  channel  | dir | beat contents                        | handshake
//  ---------+-----+--------------------------------------+-------------
//  i_pair   | in  | a_x .. f_y, six signed vertices      | valid/ready
//  o_res    | out | overlap, one bit                     | valid/ready
//
//  one beat per cycle sustained while o_res is not stalled, each pair passing the stages below
//  stages: input register, product registers (multipliers), result register
//  ready falls only when all three stages hold a beat and o_res is stalled
//  synchronous active-low reset empties the pipe, payload is not reset
// ----------------------------------------------------------------------------
module triangle_overlap_test_2d #(
    parameter int COORD_WIDTH = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    tot_pair_if.sink i_pair,
    tot_res_if.source o_res
);

    localparam int NE = tot_pkg::NUM_EDGES;

    // stage valids
    logic r_v1, r_v2, r_v3;
    logic free1, free2, free3;

    // a stage can load when it is empty or its beat moves on this edge
    assign free3 = !r_v3 || o_res.ready;
    assign free2 = !r_v2 || free3;
    assign free1 = !r_v1 || free2;

    assign i_pair.ready = free1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (free1) begin
                r_v1 <= i_pair.valid;
            end
            if (free2) begin
                r_v2 <= r_v1;
            end
            if (free3) begin
                r_v3 <= r_v2;
            end
        end
    end

    // input register, first triangle in p, second in q
    logic signed [COORD_WIDTH-1:0] r_px [NE];
    logic signed [COORD_WIDTH-1:0] r_py [NE];
    logic signed [COORD_WIDTH-1:0] r_qx [NE];
    logic signed [COORD_WIDTH-1:0] r_qy [NE];

    always_ff @(posedge i_clk) begin
        if (free1) begin
            r_px[0] <= i_pair.a_x;
            r_py[0] <= i_pair.a_y;
            r_px[1] <= i_pair.b_x;
            r_py[1] <= i_pair.b_y;
            r_px[2] <= i_pair.c_x;
            r_py[2] <= i_pair.c_y;
            r_qx[0] <= i_pair.d_x;
            r_qy[0] <= i_pair.d_y;
            r_qx[1] <= i_pair.e_x;
            r_qy[1] <= i_pair.e_y;
            r_qx[2] <= i_pair.f_x;
            r_qy[2] <= i_pair.f_y;
        end
    end

    // edge pairs: each edge of the first triangle against each edge of the second
    logic [NE*NE-1:0] meet;

    for (genvar gi = 0; gi < NE; gi++) begin : g_p
        for (genvar gj = 0; gj < NE; gj++) begin : g_q
            tot_edge_pair #(
                .COORD_WIDTH(COORD_WIDTH)
            ) u_edge (
                .i_clk  (i_clk),
                .i_en   (free2),
                .i_p0_x (r_px[gi]),
                .i_p0_y (r_py[gi]),
                .i_p1_x (r_px[tot_pkg::next_vtx(gi)]),
                .i_p1_y (r_py[tot_pkg::next_vtx(gi)]),
                .i_q0_x (r_qx[gj]),
                .i_q0_y (r_qy[gj]),
                .i_q1_x (r_qx[tot_pkg::next_vtx(gj)]),
                .i_q1_y (r_qy[tot_pkg::next_vtx(gj)]),
                .o_meet (meet[gi*NE+gj])
            );
        end
    end

    // containment: a inside def, d inside abc
    logic a_in_def, d_in_abc;

    tot_inside #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_a_in (
        .i_clk    (i_clk),
        .i_en     (free2),
        .i_pt_x   (r_px[0]),
        .i_pt_y   (r_py[0]),
        .i_t0_x   (r_qx[0]),
        .i_t0_y   (r_qy[0]),
        .i_t1_x   (r_qx[1]),
        .i_t1_y   (r_qy[1]),
        .i_t2_x   (r_qx[2]),
        .i_t2_y   (r_qy[2]),
        .o_inside (a_in_def)
    );

    tot_inside #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_d_in (
        .i_clk    (i_clk),
        .i_en     (free2),
        .i_pt_x   (r_qx[0]),
        .i_pt_y   (r_qy[0]),
        .i_t0_x   (r_px[0]),
        .i_t0_y   (r_py[0]),
        .i_t1_x   (r_px[1]),
        .i_t1_y   (r_py[1]),
        .i_t2_x   (r_px[2]),
        .i_t2_y   (r_py[2]),
        .o_inside (d_in_abc)
    );

    // result register
    logic r_overlap, n_overlap;

    assign n_overlap = (|meet) || a_in_def || d_in_abc;

    always_ff @(posedge i_clk) begin
        if (free3) begin
            r_overlap <= n_overlap;
        end
    end

    assign o_res.valid   = r_v3;
    assign o_res.overlap = r_overlap;

endmodule

@@ rtl/tot_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tot_checker
// port-level checks of the overlap test, bound to the top level
// ----------------------------------------------------------------------------
module tot_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_out_overlap
);

    logic in_beat;

    assign in_beat = i_in_valid && i_in_ready;

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    // and keeps its value
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_overlap))
        else $error("result changed while stalled");

    // input backpressure only comes from a stalled output
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid && !i_out_ready)
        else $error("input blocked without output stall");

    // with the output taking results and no new beat, the drained pipe leaves nothing to deliver
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_ready && !in_beat) ##1 (i_out_ready && !in_beat)
            ##1 (i_out_ready && !in_beat) |=> !i_out_valid)
        else $error("result appeared from an empty pipe");

endmodule

bind triangle_overlap_test_2d tot_checker u_tot_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_pair.valid),
    .i_in_ready    (i_pair.ready),
    .i_out_valid   (o_res.valid),
    .i_out_ready   (o_res.ready),
    .i_out_overlap (o_res.overlap)
);

@@ dv/tot_overlap_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tot_overlap_checker
// watches the pair and result channels, works out the overlap flag of every
// accepted pair with exact integer geometry and compares it with the result
// beats in order
// ----------------------------------------------------------------------------
module tot_overlap_checker (
    input  logic  i_clk,
    input  logic  i_rst_n,
    tot_pair_if   i_pair,
    tot_res_if    i_res,
    output int    o_errors,
    output int    o_pending
);

    typedef struct {
        longint x;
        longint y;
    } t_pt;

    logic overlap_exp_q[$];
    logic want;
    int   err_cnt = 0;
    int   res_idx = 0;

    function automatic t_pt as_pt(input longint x, input longint y);
        t_pt p;
        p.x = x;
        p.y = y;
        return p;
    endfunction

    function automatic t_pt sub2(input t_pt u, input t_pt v);
        return as_pt(u.x - v.x, u.y - v.y);
    endfunction

    function automatic longint cross2(input t_pt u, input t_pt v);
        return u.x * v.y - u.y * v.x;
    endfunction

    function automatic longint dot2(input t_pt u, input t_pt v);
        return u.x * v.x + u.y * v.y;
    endfunction

    function automatic longint orient(input t_pt o, input t_pt u, input t_pt v);
        return cross2(sub2(u, o), sub2(v, o));
    endfunction

    function automatic logic at_origin(input t_pt v);
        return (v.x == 0) && (v.y == 0);
    endfunction

    // point on a segment of non-zero length, ends included
    function automatic logic pt_on_seg(input t_pt pt, input t_pt s0, input t_pt s1);
        t_pt    sd;
        t_pt    w;
        longint k;
        sd = sub2(s1, s0);
        w  = sub2(pt, s0);
        if (cross2(w, sd) != 0)
            return 1'b0;
        k = dot2(w, sd);
        return (k >= 0) && (k <= dot2(sd, sd));
    endfunction

    function automatic logic segs_touch(input t_pt p0, input t_pt p1,
                                        input t_pt q0, input t_pt q1);
        t_pt    r;
        t_pt    s;
        t_pt    w;
        longint den;
        longint tn;
        longint un;
        longint rr;
        longint n0;
        longint n1;
        longint lo;
        longint hi;
        r = sub2(p1, p0);
        s = sub2(q1, q0);
        w = sub2(q0, p0);
        if (at_origin(r)) begin
            if (at_origin(s))
                return at_origin(w);
            return pt_on_seg(p0, q0, q1);
        end
        den = cross2(r, s);
        if (den == 0) begin
            // parallel: only a collinear pair can meet, judged along r
            if (cross2(w, r) != 0)
                return 1'b0;
            rr = dot2(r, r);
            n0 = dot2(w, r);
            n1 = dot2(sub2(q1, p0), r);
            lo = (n0 < n1) ? n0 : n1;
            hi = (n0 < n1) ? n1 : n0;
            return (hi >= 0) && (lo <= rr);
        end
        tn = cross2(w, s);
        un = cross2(w, r);
        if (den < 0) begin
            den = -den;
            tn  = -tn;
            un  = -un;
        end
        return (tn >= 0) && (tn <= den) && (un >= 0) && (un <= den);
    endfunction

    // flat triangles have no interior
    function automatic logic pt_in_tri(input t_pt pt, input t_pt t0,
                                       input t_pt t1, input t_pt t2);
        longint o1;
        longint o2;
        longint o3;
        logic   neg;
        logic   pos;
        if (orient(t0, t1, t2) == 0)
            return 1'b0;
        o1  = orient(t0, t1, pt);
        o2  = orient(t1, t2, pt);
        o3  = orient(t2, t0, pt);
        neg = (o1 < 0) || (o2 < 0) || (o3 < 0);
        pos = (o1 > 0) || (o2 > 0) || (o3 > 0);
        return !(neg && pos);
    endfunction

    function automatic logic pair_overlaps(input t_pt a, input t_pt b, input t_pt c,
                                           input t_pt d, input t_pt e, input t_pt f);
        t_pt  p[3];
        t_pt  q[3];
        logic hit;
        p[0] = a;
        p[1] = b;
        p[2] = c;
        q[0] = d;
        q[1] = e;
        q[2] = f;
        hit  = 1'b0;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                if (!hit)
                    hit = segs_touch(p[i], p[(i + 1) % 3], q[j], q[(j + 1) % 3]);
        if (!hit)
            hit = pt_in_tri(p[0], q[0], q[1], q[2]) || pt_in_tri(q[0], p[0], p[1], p[2]);
        return hit;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            // results first: a result beat never belongs to a pair taken at this edge
            if (i_res.valid && i_res.ready) begin
                if (overlap_exp_q.size() == 0) begin
                    err_cnt++;
                    $display("%0t result %0d unexpected: expected none, got overlap=%b",
                             $time, res_idx, i_res.overlap);
                end else begin
                    want = overlap_exp_q.pop_front();
                    if (i_res.overlap !== want) begin
                        err_cnt++;
                        $display("%0t result %0d mismatch: expected overlap=%b, got %b",
                                 $time, res_idx, want, i_res.overlap);
                    end
                end
                res_idx++;
            end
            if (i_pair.valid && i_pair.ready)
                overlap_exp_q.push_back(pair_overlaps(
                    as_pt(i_pair.a_x, i_pair.a_y), as_pt(i_pair.b_x, i_pair.b_y),
                    as_pt(i_pair.c_x, i_pair.c_y), as_pt(i_pair.d_x, i_pair.d_y),
                    as_pt(i_pair.e_x, i_pair.e_y), as_pt(i_pair.f_x, i_pair.f_y)));
        end
        o_pending <= overlap_exp_q.size();
        o_errors  <= err_cnt;
    end

endmodule

@@ dv/tb_triangle_overlap_test_2d.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_triangle_overlap_test_2d
// drives triangle pairs into the overlap tester and judges its answers
//
// a short run of hand-built shapes (crossing, containment, shared and touching
// edges, parallel edges, point and flat triangles, coordinate extremes) is
// followed by random pairs drawn from several geometries. both channels stall
// at random; the checker beside the block predicts every flag and compares
// ----------------------------------------------------------------------------
module tb_triangle_overlap_test_2d;

    localparam int CW          = 16;
    localparam int NUM_PAIRS   = 600;
    localparam int HOLD_CYCLES = 80;
    localparam int STALL_LIMIT = 2000;
    localparam int CALM_FROM   = 150;
    localparam int CALM_TO     = 300;
    localparam int HOLD_AT     = 400;
    localparam int DRAIN_AT    = 500;

    typedef logic signed [CW-1:0] t_coord;

    typedef struct {
        t_coord a_x, a_y, b_x, b_y, c_x, c_y;
        t_coord d_x, d_y, e_x, e_y, f_x, f_y;
    } t_tri_pair;

    logic i_clk;
    logic i_rst_n;

    tot_pair_if #(.COORD_WIDTH(CW)) pair_if ();
    tot_res_if                      res_if ();

    int   err_count;
    int   exp_pending;
    int   n_sent      = 0;
    int   n_directed  = 0;
    int   idle_cycles = 0;
    logic calm        = 1'b0;   // both sides stop idling while set
    logic hold_go     = 1'b0;   // asks the result side for its long hold-off

    triangle_overlap_test_2d #(.COORD_WIDTH(CW)) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pair  (pair_if),
        .o_res   (res_if)
    );

    tot_overlap_checker u_chk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_pair    (pair_if),
        .i_res     (res_if),
        .o_errors  (err_count),
        .o_pending (exp_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    function automatic t_tri_pair pair_of(input int ax, input int ay, input int bx,
                                          input int by, input int cx, input int cy,
                                          input int dx, input int dy, input int ex,
                                          input int ey, input int fx, input int fy);
        t_tri_pair tp;
        tp.a_x = t_coord'(ax);
        tp.a_y = t_coord'(ay);
        tp.b_x = t_coord'(bx);
        tp.b_y = t_coord'(by);
        tp.c_x = t_coord'(cx);
        tp.c_y = t_coord'(cy);
        tp.d_x = t_coord'(dx);
        tp.d_y = t_coord'(dy);
        tp.e_x = t_coord'(ex);
        tp.e_y = t_coord'(ey);
        tp.f_x = t_coord'(fx);
        tp.f_y = t_coord'(fy);
        return tp;
    endfunction

    // uniform in [-r, r]
    function automatic int spread(input int r);
        return int'($urandom_range(0, 2 * r)) - r;
    endfunction

    // values at and next to the ends of the coordinate range and around zero, else random
    function automatic int edge_coord();
        case ($urandom_range(0, 7))
            0: return -32768;
            1: return -32767;
            2: return -1;
            3: return 0;
            4: return 1;
            5: return 32766;
            6: return 32767;
            default: return int'(t_coord'($urandom));
        endcase
    endfunction

    function automatic t_tri_pair make_random_pair();
        int v[12];
        int sel;
        int bx;
        int by;
        int ux;
        int uy;
        int rot;
        int j;
        sel = $urandom_range(0, 99);
        if (sel < 20) begin
            // whole range, every bit of every coordinate toggles
            for (int i = 0; i < 12; i++)
                v[i] = int'(t_coord'($urandom));
        end else if (sel < 30) begin
            for (int i = 0; i < 12; i++)
                v[i] = edge_coord();
        end else if (sel < 55) begin
            // tiny grid: lots of shared points, flat and point triangles
            for (int i = 0; i < 12; i++)
                v[i] = spread(4);
        end else if (sel < 70) begin
            // both triangles scattered around one centre
            bx = spread(30000);
            by = spread(30000);
            for (int i = 0; i < 6; i++) begin
                v[2 * i]     = bx + spread(300);
                v[2 * i + 1] = by + spread(300);
            end
        end else if (sel < 85) begin
            // A, B, D, E on one line: collinear overlap, touching and gaps
            bx = spread(1000);
            by = spread(1000);
            ux = spread(6);
            uy = spread(6);
            for (int i = 0; i < 6; i++) begin
                if (i == 2 || i == 5) begin
                    v[2 * i]     = bx + spread(40);
                    v[2 * i + 1] = by + spread(40);
                end else begin
                    j            = spread(5);
                    v[2 * i]     = bx + j * ux;
                    v[2 * i + 1] = by + j * uy;
                end
            end
        end else begin
            // second triangle is the first one, reordered and maybe nudged
            bx  = spread(20000);
            by  = spread(20000);
            rot = $urandom_range(0, 2);
            for (int i = 0; i < 3; i++) begin
                v[2 * i]     = bx + spread(50);
                v[2 * i + 1] = by + spread(50);
            end
            for (int i = 0; i < 3; i++) begin
                j                  = (i + rot) % 3;
                v[6 + 2 * i]       = v[2 * j];
                v[6 + 2 * i + 1]   = v[2 * j + 1];
                if ($urandom_range(0, 1) == 1) begin
                    v[6 + 2 * i]     = v[6 + 2 * i] + spread(2);
                    v[6 + 2 * i + 1] = v[6 + 2 * i + 1] + spread(2);
                end
            end
        end
        return pair_of(v[0], v[1], v[2], v[3], v[4], v[5],
                       v[6], v[7], v[8], v[9], v[10], v[11]);
    endfunction

    // offers one pair and returns once it has been taken
    task automatic offer_pair(input t_tri_pair tp);
        logic quiet;
        quiet = (n_sent >= CALM_FROM) && (n_sent < CALM_TO);
        calm <= quiet;
        while (!quiet && $urandom_range(0, 99) < 19) begin
            pair_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        pair_if.valid <= 1'b1;
        pair_if.a_x   <= tp.a_x;
        pair_if.a_y   <= tp.a_y;
        pair_if.b_x   <= tp.b_x;
        pair_if.b_y   <= tp.b_y;
        pair_if.c_x   <= tp.c_x;
        pair_if.c_y   <= tp.c_y;
        pair_if.d_x   <= tp.d_x;
        pair_if.d_y   <= tp.d_y;
        pair_if.e_x   <= tp.e_x;
        pair_if.e_y   <= tp.e_y;
        pair_if.f_x   <= tp.f_x;
        pair_if.f_y   <= tp.f_y;
        @(posedge i_clk);
        while (!pair_if.ready)
            @(posedge i_clk);
        n_sent++;
    endtask

    // directed shapes, counted so the random part tops up to the total
    task automatic offer_shape(input t_tri_pair tp);
        offer_pair(tp);
        n_directed++;
    endtask

    // ------------------------------------------------------------------
    // sender: reset, directed shapes, random pairs, drain and verdict
    // ------------------------------------------------------------------
    initial begin
        i_rst_n       <= 1'b0;
        pair_if.valid <= 1'b0;
        pair_if.a_x   <= '0;
        pair_if.a_y   <= '0;
        pair_if.b_x   <= '0;
        pair_if.b_y   <= '0;
        pair_if.c_x   <= '0;
        pair_if.c_y   <= '0;
        pair_if.d_x   <= '0;
        pair_if.d_y   <= '0;
        pair_if.e_x   <= '0;
        pair_if.e_y   <= '0;
        pair_if.f_x   <= '0;
        pair_if.f_y   <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // identical triangles
        offer_shape(pair_of(0, 0, 10, 0, 0, 10, 0, 0, 10, 0, 0, 10));
        // far apart
        offer_shape(pair_of(0, 0, 10, 0, 0, 10, 100, 100, 110, 100, 100, 110));
        // edges cross properly
        offer_shape(pair_of(0, 0, 10, 0, 0, 10, 5, -5, 5, 20, 20, 20));
        // second triangle wholly inside the first, no edge contact
        offer_shape(pair_of(0, 0, 100, 0, 0, 100, 10, 10, 20, 10, 10, 20));
        // first triangle wholly inside the second
        offer_shape(pair_of(10, 10, 20, 10, 10, 20, 0, 0, 100, 0, 0, 100));
        // only a shared corner
        offer_shape(pair_of(0, 0, 10, 0, 0, 10, 10, 0, 20, 0, 20, 10));
        // collinear edges overlapping in part
        offer_shape(pair_of(0, 0, 10, 0, 0, 10, 5, 0, 15, 0, 10, -10));
        // collinear edges on one line with a gap between them
        offer_shape(pair_of(0, 0, 10, 0, 0, 10, 11, 0, 20, 0, 15, -5));
        // collinear edges meeting end to end
        offer_shape(pair_of(0, 0, 10, 0, 0, 10, -10, 0, 0, 0, -5, -5));
        // parallel edges one unit apart
        offer_shape(pair_of(0, 0, 10, 0, 0, 10, 0, -1, 10, -1, 5, -10));
        // an edge shrunk to a point lying on the other triangle's edge
        offer_shape(pair_of(0, 0, 10, 0, 0, 10, 5, 0, 5, 0, 5, -10));
        // both triangles the same single point
        offer_shape(pair_of(3, 3, 3, 3, 3, 3, 3, 3, 3, 3, 3, 3));
        // two different single points
        offer_shape(pair_of(3, 3, 3, 3, 3, 3, 4, 4, 4, 4, 4, 4));
        // flat second triangle floating inside the first
        offer_shape(pair_of(0, 0, 100, 0, 0, 100, 10, 10, 20, 20, 30, 30));
        // flat first triangle through a point of the second
        offer_shape(pair_of(0, 0, 10, 10, 20, 20, 5, 5, 5, 5, 5, 5));
        // flat first triangle, point beside it
        offer_shape(pair_of(0, 0, 10, 10, 20, 20, 5, 6, 5, 6, 5, 6));
        // largest triangle against a small triangle in the far corner of the range
        offer_shape(pair_of(-32768, -32768, 32767, -32768, -32768, 32767,
                            32767, 32767, 32767, 32766, 32766, 32767));
        // largest triangle against a unit triangle at the origin, just past its hypotenuse
        offer_shape(pair_of(-32768, -32768, 32767, -32768, -32768, 32767,
                            0, 0, 1, 0, 0, 1));
        // largest triangle and its mirror share the hypotenuse
        offer_shape(pair_of(-32768, -32768, 32767, -32768, -32768, 32767,
                            32767, 32767, -32768, 32767, 32767, -32768));
        // every coordinate at the negative end, then the first triangle at the positive end
        offer_shape(pair_of(-32768, -32768, -32768, -32768, -32768, -32768,
                            -32768, -32768, -32768, -32768, -32768, -32768));
        offer_shape(pair_of(32767, 32767, 32767, 32767, 32767, 32767,
                            -1, -1, -1, -1, -1, -1));
        // thin slivers spanning the full range, crossing near the origin
        offer_shape(pair_of(-32768, 0, 32767, 1, 32767, 0,
                            0, -32768, 1, 32767, 0, 32767));

        while (n_sent < NUM_PAIRS) begin
            offer_pair(make_random_pair());
            // result side holds off while pairs keep coming, the pipe fills
            if (n_sent == HOLD_AT)
                hold_go <= 1'b1;
            // input pauses until every outstanding flag has come back
            if (n_sent == DRAIN_AT) begin
                pair_if.valid <= 1'b0;
                @(posedge i_clk);
                while (exp_pending != 0)
                    @(posedge i_clk);
            end
        end
        pair_if.valid <= 1'b0;
        calm          <= 1'b0;

        // drain, then wait for any stray beats
        @(posedge i_clk);
        while (exp_pending != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("pairs sent: %0d, %0d hand-built, the rest drawn from full-range, extreme,",
                 n_sent, n_directed);
        $display("grid, collinear and near-copy geometry; output held off %0d cycles once",
                 HOLD_CYCLES);
        if (err_count == 0)
            $display("[triangle_overlap_test_2d] OK");
        else
            $display("[triangle_overlap_test_2d] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // receiver: random stalls, one calm window, one long hold-off
    // ------------------------------------------------------------------
    initial begin
        int   hold_left;
        logic held_done;
        hold_left    = 0;
        held_done    = 1'b0;
        res_if.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n)
            @(posedge i_clk);
        forever begin
            if (hold_left > 0) begin
                res_if.ready <= 1'b0;
                hold_left--;
            end else if (hold_go && !held_done) begin
                held_done    = 1'b1;
                hold_left    = HOLD_CYCLES - 1;
                res_if.ready <= 1'b0;
            end else if (calm) begin
                res_if.ready <= 1'b1;
            end else begin
                res_if.ready <= ($urandom_range(0, 99) >= 19);
            end
            @(posedge i_clk);
        end
    end

    // ------------------------------------------------------------------
    // watchdog: too long without a beat on either channel ends the run
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if ((pair_if.valid && pair_if.ready) || (res_if.valid && res_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t no beat for %0d cycles, %0d flags outstanding",
                     $time, idle_cycles, exp_pending);
            $display("[triangle_overlap_test_2d] ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

@@ files.f @@
rtl/tot_pkg.sv
rtl/tot_if.sv
rtl/tot_edge_pair.sv
rtl/tot_inside.sv
rtl/triangle_overlap_test_2d.sv
rtl/tot_checker.sv
dv/tot_overlap_checker.sv
dv/tb_triangle_overlap_test_2d.sv
